// ===== rtl/core/pmoa_pkg.sv =====
// shared types and constants for the power monitor oversample averager
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pmoa_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_OVERSAMPLE = 2'd0;
  localparam logic [1:0] REG_CHANNEL    = 2'd1;
  localparam logic [1:0] REG_KIND       = 2'd2;

  // measurement kinds (code three behaves as microamp)
  localparam logic [1:0] KIND_VOLT      = 2'd0;
  localparam logic [1:0] KIND_MILLIAMP  = 2'd1;
  localparam logic [1:0] KIND_MICROAMP  = 2'd2;

  // monitored nets
  localparam logic [1:0] CH_BATTERY     = 2'd1;
  localparam logic [1:0] CH_ACC_BATTERY = 2'd2;
  localparam logic [1:0] CH_MICROAMP    = 2'd3;

  localparam logic [3:0] MAX_OVERSAMPLE_LOG2 = 4'd15;

  // reciprocal multipliers, exact over the 16-bit magnitude range
  localparam logic [15:0] DIV51_RECIP   = 16'd41121;
  localparam int          DIV51_SHIFT   = 21;
  localparam logic [15:0] DIV1000_RECIP = 16'd33555;
  localparam int          DIV1000_SHIFT = 25;

  typedef struct packed {
    logic [3:0] oversample_log2;
    logic [1:0] channel;
    logic [1:0] measure_kind;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] avg;
    logic               milli_ch3;
  } avg_t;

endpackage

// ===== rtl/core/pmoa_scale.sv =====
// input register and per-sample scaling stage
// depends on pmoa_pkg
`timescale 1ns / 1ps

module pmoa_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmoa_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        raw_sample_i,
  output logic               scl_valid_o,
  input  logic               scl_ready_i,
  output logic signed [15:0] scaled_o
);
  import pmoa_pkg::*;

  logic               raw_valid_q;
  logic [15:0]        raw_q;
  logic               scl_valid_q;
  logic signed [15:0] scaled_q;
  logic signed [15:0] scaled_d;
  logic               scl_free;
  logic               raw_free;
  logic signed [15:0] raw_s;
  logic signed [15:0] half;
  logic [15:0]        mag;
  logic [31:0]        prod;
  logic signed [15:0] q51;
  logic signed [15:0] d51;

  assign scl_free   = !scl_valid_q || scl_ready_i;
  assign raw_free   = !raw_valid_q || scl_free;
  assign in_ready_o = raw_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_valid_q <= 1'b0;
      scl_valid_q <= 1'b0;
    end else begin
      if (raw_free) raw_valid_q <= in_valid_i;
      if (scl_free) scl_valid_q <= raw_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && raw_free) raw_q <= raw_sample_i;
    if (raw_valid_q && scl_free) scaled_q <= scaled_d;
  end

  // divide by 51 truncating toward zero on the magnitude
  always_comb begin
    raw_s = signed'(raw_q);
    half  = raw_s >>> 1;
    mag   = raw_s[15] ? 16'(-raw_s) : raw_q;
    prod  = mag * DIV51_RECIP;
    q51   = signed'({5'd0, prod[31:DIV51_SHIFT]});
    d51   = raw_s[15] ? -q51 : q51;
  end

  always_comb begin
    case (cfg_i.measure_kind)
      KIND_VOLT: scaled_d = half;
      KIND_MILLIAMP: begin
        if (cfg_i.channel <= CH_BATTERY) scaled_d = half;
        else if (cfg_i.channel == CH_ACC_BATTERY) scaled_d = d51;
        else scaled_d = raw_s;
      end
      default: scaled_d = (cfg_i.channel == CH_MICROAMP) ? raw_s : 16'sd0;
    endcase
  end

  assign scl_valid_o = scl_valid_q;
  assign scaled_o    = scaled_q;

endmodule

// ===== rtl/core/pmoa_accum.sv =====
// running sum, window counter and averaging shift
// depends on pmoa_pkg
`timescale 1ns / 1ps

module pmoa_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmoa_pkg::cfg_t     cfg_i,
  input  logic               clear_i,
  input  logic               scl_valid_i,
  output logic               scl_ready_o,
  input  logic signed [15:0] scaled_i,
  output logic               avg_valid_o,
  input  logic               avg_ready_i,
  output pmoa_pkg::avg_t     avg_o
);
  import pmoa_pkg::*;

  logic [31:0]        sum_q;
  logic [31:0]        sum_d;
  logic [15:0]        cnt_q;
  logic [15:0]        cnt_inc;
  logic [3:0]         shift;
  logic [15:0]        target;
  logic               done;
  logic               avg_free;
  logic               fire;
  logic signed [31:0] sum_sh;
  logic               avg_valid_q;
  avg_t               avg_q;

  always_comb begin
    shift    = (cfg_i.oversample_log2 > MAX_OVERSAMPLE_LOG2) ? MAX_OVERSAMPLE_LOG2
                                                             : cfg_i.oversample_log2;
    target   = 16'd1 << shift;
    cnt_inc  = cnt_q + 16'd1;
    done     = (cnt_inc == target);
    sum_d    = sum_q + {{16{scaled_i[15]}}, scaled_i};
    sum_sh   = signed'(sum_d) >>> shift;
    avg_free = !avg_valid_q || avg_ready_i;
    fire     = scl_valid_i && (!done || avg_free);
  end

  // only a window-closing transfer needs the average slot
  assign scl_ready_o = !done || avg_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      avg_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else if (fire) begin
        sum_q <= done ? '0 : sum_d;
        cnt_q <= done ? '0 : cnt_inc;
      end
      if (fire && done) avg_valid_q <= 1'b1;
      else if (avg_ready_i) avg_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && done) begin
      avg_q.avg       <= sum_sh[15:0];
      avg_q.milli_ch3 <= (cfg_i.measure_kind == KIND_MILLIAMP) &&
                         (cfg_i.channel == CH_MICROAMP);
    end
  end

  assign avg_valid_o = avg_valid_q;
  assign avg_o       = avg_q;

endmodule

// ===== rtl/core/pmoa_out.sv =====
// milliamp divide by 1000 and result register
// depends on pmoa_pkg
`timescale 1ns / 1ps

module pmoa_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avg_valid_i,
  output logic               avg_ready_o,
  input  pmoa_pkg::avg_t     avg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] average_value_o
);
  import pmoa_pkg::*;

  logic               out_valid_q;
  logic signed [15:0] out_q;
  logic signed [15:0] res_d;
  logic               out_free;
  logic [15:0]        mag;
  logic [31:0]        prod;
  logic signed [15:0] q;
  logic signed [15:0] qs;

  assign out_free    = !out_valid_q || out_ready_i;
  assign avg_ready_o = out_free;

  // truncating divide by 1000 on the magnitude, sign restored after
  always_comb begin
    mag   = avg_i.avg[15] ? 16'(-avg_i.avg) : 16'(avg_i.avg);
    prod  = mag * DIV1000_RECIP;
    q     = signed'({9'd0, prod[31:DIV1000_SHIFT]});
    qs    = avg_i.avg[15] ? -q : q;
    res_d = avg_i.milli_ch3 ? qs : avg_i.avg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= avg_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (avg_valid_i && out_free) out_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign average_value_o = out_q;

endmodule

// ===== rtl/core/power_monitor_oversample_averager.sv =====
// top level: configuration registers and the four-stage averaging pipeline
// depends on pmoa_pkg, pmoa_scale, pmoa_accum, pmoa_out
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i/in_ready_o, raw_sample_i  | sink
//  out     | out_valid_o/out_ready_i, avg value   | source
//  cfg     | cfg_valid_i/cfg_ready_o, index, data | sink
//
// one sample transfer per cycle while in_ready_o is high; a result leaves the
// output register after the transfer that closes its window has passed the input,
// scale, accumulate and divide registers. reset clears the configuration registers,
// valid flags, sum and count. a stalled output only holds back the sample that
// closes the next window; other samples keep flowing into the running sum. cfg
// writes to the three known indexes restart the window.
`timescale 1ns / 1ps

module power_monitor_oversample_averager (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] raw_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] average_value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [3:0]         cfg_data_i
);
  import pmoa_pkg::*;

  cfg_t               cfg_q;
  logic               cfg_fire;
  logic               clear_q;
  logic               scl_valid;
  logic               scl_ready;
  logic signed [15:0] scaled;
  logic               avg_valid;
  logic               avg_ready;
  avg_t               avg;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      clear_q <= 1'b0;
    end else begin
      clear_q <= 1'b0;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          REG_OVERSAMPLE: begin
            cfg_q.oversample_log2 <= cfg_data_i;
            clear_q               <= 1'b1;
          end
          REG_CHANNEL: begin
            cfg_q.channel <= cfg_data_i[1:0];
            clear_q       <= 1'b1;
          end
          REG_KIND: begin
            cfg_q.measure_kind <= cfg_data_i[1:0];
            clear_q            <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  pmoa_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_sample_i (raw_sample_i),
    .scl_valid_o  (scl_valid),
    .scl_ready_i  (scl_ready),
    .scaled_o     (scaled)
  );

  pmoa_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clear_i     (clear_q),
    .scl_valid_i (scl_valid),
    .scl_ready_o (scl_ready),
    .scaled_i    (scaled),
    .avg_valid_o (avg_valid),
    .avg_ready_i (avg_ready),
    .avg_o       (avg)
  );

  pmoa_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avg_valid_i     (avg_valid),
    .avg_ready_o     (avg_ready),
    .avg_i           (avg),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .average_value_o (average_value_o)
  );

endmodule

// ===== dv/power_monitor_oversample_averager_tb.sv =====
// testbench for the power monitor oversample averager: directed corners, then random
// windows with random idling, each average compared with a model of the window sum
// depends on pmoa_pkg and power_monitor_oversample_averager
`timescale 1ns / 1ps

module power_monitor_oversample_averager_tb;
  import pmoa_pkg::*;

  localparam logic [1:0] CH_EXT_SUPPLY = 2'd0;
  localparam logic [1:0] KIND_CODE3    = 2'd3;
  localparam logic [1:0] REG_UNUSED    = 2'd3;
  localparam int         DRAIN_CYCLES  = 16;
  localparam int         WIDE_LOG2     = 8;
  localparam int         CYCLE_LIMIT   = 3_000_000;

  // per-window model of the averager: scaled running sum, sample count and
  // the averages still owed by the block
  class window_average_model;
    logic [3:0]         os_log2;
    logic [1:0]         chan;
    logic [1:0]         kind;
    int                 running_sum;
    int                 samples_taken;
    logic signed [15:0] pending_averages[$];
    int                 n_errors;
    int                 n_samples;
    int                 n_averages;

    function new();
      os_log2       = 4'd0;
      chan          = CH_EXT_SUPPLY;
      kind          = KIND_VOLT;
      running_sum   = 0;
      samples_taken = 0;
      n_errors      = 0;
      n_samples     = 0;
      n_averages    = 0;
    endfunction

    // any known register restarts the window
    function void apply_write(logic [1:0] idx, logic [3:0] data);
      case (idx)
        REG_OVERSAMPLE: os_log2 = data;
        REG_CHANNEL:    chan = data[1:0];
        REG_KIND:       kind = data[1:0];
        default:        return;
      endcase
      running_sum   = 0;
      samples_taken = 0;
    endfunction

    function int scaled(logic signed [15:0] raw);
      int s;
      s = raw;
      case (kind)
        KIND_VOLT: return s >>> 1;
        KIND_MILLIAMP: begin
          if (chan == CH_ACC_BATTERY) return s / 51;
          else if (chan == CH_MICROAMP) return s;
          else return s >>> 1;
        end
        // microamp and code three: only the microamp net reads non-zero
        default: return (chan == CH_MICROAMP) ? s : 0;
      endcase
    endfunction

    function void note_sample(logic signed [15:0] raw);
      int          avg;
      logic [3:0]  l;
      l = (os_log2 > MAX_OVERSAMPLE_LOG2) ? MAX_OVERSAMPLE_LOG2 : os_log2;
      running_sum += scaled(raw);
      samples_taken++;
      n_samples++;
      if (samples_taken < (1 << l)) return;
      avg = running_sum >>> l;
      if (kind == KIND_MILLIAMP && chan == CH_MICROAMP) avg = avg / 1000;
      running_sum   = 0;
      samples_taken = 0;
      pending_averages.push_back(avg[15:0]);
    endfunction

    task report(string what, logic signed [15:0] got, logic signed [15:0] want);
      n_errors++;
      if (n_errors <= 40)
        $display("%0t: %s: average_value got %0d, want %0d", $time, what, got, want);
    endtask

    task check_average(logic signed [15:0] got);
      logic signed [15:0] want;
      n_averages++;
      if (pending_averages.size() == 0) begin
        report("result with no window closed", got, 16'sd0);
      end else begin
        want = pending_averages.pop_front();
        if (got !== want) report("average mismatch", got, want);
      end
    endtask
  endclass

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] raw_sample_i    = 16'sd0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic signed [15:0] average_value_o;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i     = REG_OVERSAMPLE;
  logic [3:0]         cfg_data_i      = 4'd0;

  window_average_model avg_model;
  bit                  stall_free  = 1'b0;
  int                  n_settings  = 0;
  int                  cycle_count = 0;

  power_monitor_oversample_averager i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .raw_sample_i   (raw_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .average_value_o(average_value_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL power_monitor_oversample_averager");
      $finish;
    end
  end

  // every output transfer is checked against the oldest closed window
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) avg_model.check_average(average_value_o);
  end

  // output back-pressure in random bursts, off while stall_free is set
  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (!stall_free && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  function automatic logic signed [15:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'($urandom_range(0, 2100));
      3:       return 16'(0 - int'($urandom_range(0, 2100)));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic signed [15:0] raw, input bit may_idle);
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (!in_ready_o);
    avg_model.note_sample(raw);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [3:0] data, input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid_i <= 1'b0;
    avg_model.apply_write(idx, data);
  endtask

  task automatic apply_config(input logic [3:0] os, input logic [3:0] ch,
                              input logic [3:0] kind);
    cfg_write(REG_OVERSAMPLE, os, 1'b0);
    cfg_write(REG_CHANNEL, ch, 1'b0);
    cfg_write(REG_KIND, kind, 1'b1);
    n_settings++;
  endtask

  // partial windows leave no result behind, so let the pipeline empty too
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (avg_model.pending_averages.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(input bit allow_idle);
    logic [3:0] os;
    int         n_items;
    bit         idle_here;
    case ($urandom_range(0, 19))
      0:             os = 4'($urandom_range(7, 8));
      1, 2, 3, 4, 5: os = 4'($urandom_range(4, 6));
      default:       os = 4'($urandom_range(0, 3));
    endcase
    n_items = (1 << os) * $urandom_range(1, (os <= 3) ? 12 : 2);
    if ($urandom_range(0, 1) == 1) n_items += $urandom_range(0, (1 << os) - 1);
    idle_here = allow_idle && ($urandom_range(0, 3) != 0);
    // set before the drain so a running stall burst has ended by the first item
    stall_free = !allow_idle || ($urandom_range(0, 3) == 0);
    wait_drained();
    apply_config(os, 4'($urandom), 4'($urandom));
    repeat (n_items) push_sample(pick_raw(), idle_here);
    wait_drained();
  endtask

  initial begin
    logic signed [15:0] corner_vals[4];
    logic [1:0]         kinds[4];
    logic [1:0]         chans[4];
    corner_vals = '{16'sh8000, 16'sh7fff, -16'sd1999, -16'sd103};
    kinds       = '{KIND_VOLT, KIND_MILLIAMP, KIND_MICROAMP, KIND_CODE3};
    chans       = '{CH_EXT_SUPPLY, CH_BATTERY, CH_ACC_BATTERY, CH_MICROAMP};
    avg_model   = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: single-sample voltage windows
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(-16'sd1, 1'b0);

    // every kind on every net, one-sample windows
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 4; c++) begin
        wait_drained();
        apply_config(4'd0, 4'(chans[c]), 4'(kinds[k]));
        push_sample(corner_vals[(k + c) % 4], 1'b0);
      end
    end

    // write to the unused index must not restart a half-filled window
    wait_drained();
    apply_config(4'd1, 4'(CH_EXT_SUPPLY), 4'(KIND_VOLT));
    push_sample(-16'sd3, 1'b0);
    wait_drained();
    cfg_write(REG_UNUSED, 4'($urandom), 1'b1);
    push_sample(16'sd5, 1'b0);

    // a real register write drops the half-filled window
    wait_drained();
    push_sample(16'sh7fff, 1'b0);
    wait_drained();
    cfg_write(REG_CHANNEL, 4'(CH_EXT_SUPPLY), 1'b1);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh8000, 1'b0);

    while (avg_model.n_samples < 800) random_phase(1'b1);
    // closing stretch without idling on either side
    while (avg_model.n_samples < 980) random_phase(1'b0);

    // long window, milliamp on the microamp net
    stall_free = 1'b1;
    wait_drained();
    apply_config(4'(WIDE_LOG2), 4'(CH_MICROAMP), 4'(KIND_MILLIAMP));
    repeat (1 << WIDE_LOG2) push_sample(pick_raw(), 1'b0);
    wait_drained();

    $display("%0d samples through %0d register settings, %0d averages compared",
             avg_model.n_samples, n_settings, avg_model.n_averages);
    $display("%0d mismatches, %0d cycles", avg_model.n_errors, cycle_count);
    if (avg_model.n_errors == 0) begin
      $display("PASS power_monitor_oversample_averager");
    end else begin
      $display("FAIL power_monitor_oversample_averager");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pmoa_pkg.sv
rtl/core/pmoa_scale.sv
rtl/core/pmoa_accum.sv
rtl/core/pmoa_out.sv
rtl/core/power_monitor_oversample_averager.sv
dv/power_monitor_oversample_averager_tb.sv
